@@ design/rtphx_pkg.sv @@
// Shared types and constants for the RTP header extension parser.
package rtphx_pkg;

  localparam int unsigned MaxPacketBytes = 65535;

  typedef enum logic [2:0] {
    REC_HEADER   = 3'd0,
    REC_ONE_BYTE = 3'd1,
    REC_TWO_BYTE = 3'd2,
    REC_BAD_PROF = 3'd3,
    REC_STOPPED  = 3'd4,
    REC_END      = 3'd5,
    REC_TRUNC    = 3'd6
  } rec_kind_t;

  typedef enum logic [2:0] {
    PH_FIXED = 3'd0,
    PH_PRE   = 3'd1,
    PH_HDR   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_TAIL  = 3'd5
  } phase_t;

  localparam logic [15:0] ProfileOneByte = 16'hBEDE;
  localparam logic [15:0] ProfileTwoByte = 16'h1000;

  // One result record; fields not used by a kind are zero.
  typedef struct packed {
    rec_kind_t   kind;
    logic        marker_bit;
    logic [6:0]  payload_kind;
    logic [15:0] sequence_value;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [3:0]  contributor_count;
    logic [7:0]  element_id;
    logic [15:0] element_offset;
    logic [7:0]  element_length;
    logic [7:0]  padding_bytes;
    logic        run_last;
  } record_t;

  // What one input byte yields: up to two records.
  typedef struct packed {
    logic    two;
    record_t first;
    record_t second;
  } rec_pair_t;

endpackage

@@ design/rtphx_front.sv @@
// Front part: tracks the parse of each byte and builds the records it causes.
module rtphx_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  input  logic                 byte_eop,
  output rtphx_pkg::rec_pair_t pair,
  output logic                 pair_any
);

  logic [15:0]       pos_r, pos_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [7:0]        mt_r, mt_nxt;
  logic [15:0]       seq_r, seq_nxt;
  logic [31:0]       ts_r, ts_nxt;
  logic [31:0]       ssrc_r, ssrc_nxt;
  logic [7:0]        prof_hi_r, prof_hi_nxt;
  logic [17:0]       ext_r, ext_nxt;
  logic [17:0]       cur_r, cur_nxt;
  logic [7:0]        skip_r, skip_nxt;
  logic [7:0]        pid_r, pid_nxt;
  rtphx_pkg::phase_t ph_r, ph_nxt;
  logic              two_r, two_nxt;

  rtphx_pkg::record_t rec_a, rec_b;
  logic               has_a;

  // parse-time helper values
  logic [1:0]  hl;
  logic [17:0] pre_start;
  logic [17:0] rel;
  logic [15:0] prof;
  logic [17:0] ext_full;
  logic [3:0]  ob_id;
  logic [8:0]  ob_len;
  logic [8:0]  el_len;
  logic [7:0]  el_id;
  logic        el_fit;
  logic [17:0] cur_after;
  logic [7:0]  skip_dec;
  logic        do_emit;

  always_comb begin
    hl        = two_r ? 2'd2 : 2'd1;
    pre_start = 18'd12 + {12'd0, flags_r[3:0], 2'b00};
    rel       = {2'b00, pos_r} - pre_start;
    prof      = {prof_hi_r, byte_data};
    ext_full  = {ext_r[7:0], byte_data, 2'b00};
    ob_id     = byte_data[7:4];
    ob_len    = {5'd0, byte_data[3:0]} + 9'd1;
    el_len    = (ph_r == rtphx_pkg::PH_LEN) ? {1'b0, byte_data} : ob_len;
    el_id     = (ph_r == rtphx_pkg::PH_LEN) ? pid_r : {4'd0, ob_id};
    el_fit    = (cur_r + 18'(hl) + 18'(el_len)) <= ext_r;
    cur_after = cur_r + 18'(hl) + 18'(el_len);
    skip_dec  = (skip_r != 8'd0) ? skip_r - 8'd1 : 8'd0;
  end

  always_comb begin
    pos_nxt = pos_r; flags_nxt = flags_r; mt_nxt = mt_r; seq_nxt = seq_r;
    ts_nxt = ts_r; ssrc_nxt = ssrc_r; prof_hi_nxt = prof_hi_r; ext_nxt = ext_r;
    cur_nxt = cur_r; skip_nxt = skip_r; pid_nxt = pid_r; ph_nxt = ph_r;
    two_nxt = two_r;
    rec_a = '0; has_a = 1'b0; do_emit = 1'b0;
    if (32'(pos_r) < rtphx_pkg::MaxPacketBytes) begin
      pos_nxt = pos_r + 16'd1;
      unique case (ph_r)
        rtphx_pkg::PH_FIXED: begin
          if (pos_r == 16'd0) flags_nxt = byte_data;
          else if (pos_r == 16'd1) mt_nxt = byte_data;
          else if (pos_r < 16'd4) seq_nxt = {seq_r[7:0], byte_data};
          else if (pos_r < 16'd8) ts_nxt = {ts_r[23:0], byte_data};
          else if (pos_r < 16'd12) ssrc_nxt = {ssrc_r[23:0], byte_data};
          if (pos_r == 16'd11) begin
            has_a = 1'b1;
            rec_a.kind = rtphx_pkg::REC_HEADER;
            rec_a.marker_bit = mt_r[7];
            rec_a.payload_kind = mt_r[6:0];
            rec_a.sequence_value = seq_r;
            rec_a.time_stamp = ts_r;
            rec_a.source_id = {ssrc_r[23:0], byte_data};
            rec_a.contributor_count = flags_r[3:0];
            ph_nxt = flags_r[4] ? rtphx_pkg::PH_PRE : rtphx_pkg::PH_TAIL;
          end
        end
        rtphx_pkg::PH_PRE: begin
          if ({2'b00, pos_r} >= pre_start) begin
            if (rel == 18'd0) prof_hi_nxt = byte_data;
            else if (rel == 18'd1) begin
              if (prof == rtphx_pkg::ProfileOneByte) two_nxt = 1'b0;
              else if (prof == rtphx_pkg::ProfileTwoByte) two_nxt = 1'b1;
              else begin
                has_a = 1'b1;
                rec_a.kind = rtphx_pkg::REC_BAD_PROF;
                ph_nxt = rtphx_pkg::PH_TAIL;
              end
            end else if (rel == 18'd2) ext_nxt = {10'd0, byte_data};
            else begin
              ext_nxt = ext_full;
              cur_nxt = '0;
              ph_nxt = (18'(hl) >= ext_full) ? rtphx_pkg::PH_TAIL
                                             : rtphx_pkg::PH_HDR;
            end
          end
        end
        rtphx_pkg::PH_HDR: begin
          if (byte_data == 8'd0) begin
            cur_nxt = cur_r + 18'd1;
            if (cur_r + 18'd1 + 18'(hl) >= ext_r) ph_nxt = rtphx_pkg::PH_TAIL;
          end else if (!two_r) begin
            if (ob_id == 4'd15 || ob_id == 4'd0 || !el_fit) begin
              has_a = 1'b1;
              rec_a.kind = rtphx_pkg::REC_STOPPED;
              ph_nxt = rtphx_pkg::PH_TAIL;
            end else do_emit = 1'b1;
          end else begin
            pid_nxt = byte_data;
            ph_nxt = rtphx_pkg::PH_LEN;
          end
        end
        rtphx_pkg::PH_LEN: begin
          if (!el_fit) begin
            has_a = 1'b1;
            rec_a.kind = rtphx_pkg::REC_STOPPED;
            ph_nxt = rtphx_pkg::PH_TAIL;
          end else do_emit = 1'b1;
        end
        rtphx_pkg::PH_DATA: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) ph_nxt = rtphx_pkg::PH_HDR;
        end
        default: ;
      endcase
      if (do_emit) begin
        has_a = 1'b1;
        rec_a.kind = two_r ? rtphx_pkg::REC_TWO_BYTE : rtphx_pkg::REC_ONE_BYTE;
        rec_a.element_id = el_id;
        rec_a.element_offset = 16'(18'd16 + {12'd0, flags_r[3:0], 2'b00}
                                   + cur_r + 18'(hl));
        rec_a.element_length = el_len[7:0];
        cur_nxt = cur_after;
        skip_nxt = el_len[7:0];
        if (cur_after + 18'(hl) >= ext_r) ph_nxt = rtphx_pkg::PH_TAIL;
        else if (el_len != 9'd0) ph_nxt = rtphx_pkg::PH_DATA;
        else ph_nxt = rtphx_pkg::PH_HDR;
      end
    end
    rec_b = '0;
    if (byte_eop) begin
      rec_b.kind = (ph_nxt == rtphx_pkg::PH_TAIL) ? rtphx_pkg::REC_END
                                                  : rtphx_pkg::REC_TRUNC;
      if (ph_nxt == rtphx_pkg::PH_TAIL && flags_nxt[5]) rec_b.padding_bytes = byte_data;
      rec_b.run_last = 1'b1;
      pos_nxt = '0; flags_nxt = '0; mt_nxt = '0; seq_nxt = '0; ts_nxt = '0;
      ssrc_nxt = '0; prof_hi_nxt = '0; ext_nxt = '0; cur_nxt = '0;
      skip_nxt = '0; pid_nxt = '0; ph_nxt = rtphx_pkg::PH_FIXED; two_nxt = 1'b0;
    end else begin
      rec_a.run_last = 1'b1;
    end
  end

  always_comb begin
    pair_any = byte_valid && (has_a || byte_eop);
    pair.two = has_a && byte_eop;
    pair.first = has_a ? rec_a : rec_b;
    pair.second = rec_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; flags_r <= '0; mt_r <= '0; seq_r <= '0; ts_r <= '0;
      ssrc_r <= '0; prof_hi_r <= '0; ext_r <= '0; cur_r <= '0; skip_r <= '0;
      pid_r <= '0; ph_r <= rtphx_pkg::PH_FIXED; two_r <= 1'b0;
    end else if (byte_valid) begin
      pos_r <= pos_nxt; flags_r <= flags_nxt; mt_r <= mt_nxt; seq_r <= seq_nxt;
      ts_r <= ts_nxt; ssrc_r <= ssrc_nxt; prof_hi_r <= prof_hi_nxt;
      ext_r <= ext_nxt; cur_r <= cur_nxt; skip_r <= skip_nxt; pid_r <= pid_nxt;
      ph_r <= ph_nxt; two_r <= two_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && byte_eop |=> ph_r == rtphx_pkg::PH_FIXED && pos_r == 16'd0)
    else $error("state not cleared after end of packet");
  assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == rtphx_pkg::PH_DATA |-> skip_r != 8'd0)
    else $error("data phase with nothing to skip");
  assert property (@(posedge clk) disable iff (!rst_n)
    pair_any |-> (pair.two ? pair.second.run_last : pair.first.run_last))
    else $error("last record of a byte lacks run_last");

endmodule

@@ design/rtphx_queue.sv @@
// Record queue between parse front and output side; takes pairs, gives singles.
module rtphx_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rtphx_pkg::rec_pair_t push_pair,
  output logic                 room,
  output logic                 out_valid,
  output rtphx_pkg::record_t   out_rec,
  input  logic                 out_ready
);

  localparam int unsigned Depth = 4;

  rtphx_pkg::record_t mem_r [Depth];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] n_in;

  always_comb begin
    pop       = out_valid && out_ready;
    n_in      = push ? (push_pair.two ? 3'd2 : 3'd1) : 3'd0;
    wp_nxt    = wp_r + n_in[1:0];
    rp_nxt    = rp_r + {1'b0, pop};
    cnt_nxt   = cnt_r + n_in - {2'b00, pop};
    room      = cnt_r <= 3'd2;
    out_valid = cnt_r != 3'd0;
    out_rec   = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_pair.first;
      if (push_pair.two) mem_r[wp_r + 2'd1] <= push_pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r + (push_pair.two ? 3'd2 : 3'd1) <= 3'(Depth))
    else $error("push without room");
  assert property (@(posedge clk) disable iff (!rst_n)
    !push && !pop |=> $stable(cnt_r))
    else $error("count moved while idle");

endmodule

@@ design/rtp_header_extension_parser.sv @@
// Top level of the RTP header extension parser.
// Packet bytes enter on in_packet_byte/in_end_of_packet, one item per cycle,
// when in_valid and in_ready are high. Each byte yields zero, one or two result items
// (header, element, bad profile, stopped, end or truncated records) on the
// out_ channel, with out_run_last on the last record of a byte.
// Throughput: one byte per cycle while the output side keeps up. A byte is
// parsed in the cycle it is taken; its records enter a four-record queue
// and appear on out_ the next cycle at the earliest.
// The queue depth sets how far the output may stall: in_ready drops when
// fewer than two free slots remain, and comes back as records drain.
// At reset the parse state returns to the start of a packet and the queue
// empties; after every end-of-packet byte the parse state clears as well.
// Bytes past position 65534 are not parsed; only their end flag counts.
module rtp_header_extension_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_record_kind,
  output logic        out_marker_bit,
  output logic [6:0]  out_payload_kind,
  output logic [15:0] out_sequence_value,
  output logic [31:0] out_time_stamp,
  output logic [31:0] out_source_id,
  output logic [3:0]  out_contributor_count,
  output logic [7:0]  out_element_id,
  output logic [15:0] out_element_offset,
  output logic [7:0]  out_element_length,
  output logic [7:0]  out_padding_bytes,
  output logic        out_run_last
);

  rtphx_pkg::rec_pair_t pair;
  rtphx_pkg::record_t   rec;
  logic                 pair_any;
  logic                 room;
  logic                 take;

  assign in_ready = room;
  assign take     = in_valid && room;

  rtphx_front u_front (
    .clk, .rst_n, .byte_valid(take), .byte_data(in_packet_byte),
    .byte_eop(in_end_of_packet), .pair, .pair_any
  );

  rtphx_queue u_queue (
    .clk, .rst_n, .push(pair_any), .push_pair(pair), .room,
    .out_valid, .out_rec(rec), .out_ready
  );

  assign out_record_kind       = rec.kind;
  assign out_marker_bit        = rec.marker_bit;
  assign out_payload_kind      = rec.payload_kind;
  assign out_sequence_value    = rec.sequence_value;
  assign out_time_stamp        = rec.time_stamp;
  assign out_source_id         = rec.source_id;
  assign out_contributor_count = rec.contributor_count;
  assign out_element_id        = rec.element_id;
  assign out_element_offset    = rec.element_offset;
  assign out_element_length    = rec.element_length;
  assign out_padding_bytes     = rec.padding_bytes;
  assign out_run_last          = rec.run_last;

endmodule

@@ sim/rtp_header_extension_parser_checker.sv @@
// Record predictor and scoreboard for the RTP header extension parser.
`timescale 1ns / 100ps
module rtp_header_extension_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_record_kind,
  input  logic        out_marker_bit,
  input  logic [6:0]  out_payload_kind,
  input  logic [15:0] out_sequence_value,
  input  logic [31:0] out_time_stamp,
  input  logic [31:0] out_source_id,
  input  logic [3:0]  out_contributor_count,
  input  logic [7:0]  out_element_id,
  input  logic [15:0] out_element_offset,
  input  logic [7:0]  out_element_length,
  input  logic [7:0]  out_padding_bytes,
  input  logic        out_run_last,
  output int          error_count,
  output int          pending_records
);

  rtphx_pkg::record_t expected_records[$];

  logic [15:0]       pos_q;
  logic [7:0]        flags_q, mt_q;
  logic [15:0]       seq_q, prof_q;
  logic [31:0]       ts_q, ssrc_q;
  logic [17:0]       ext_total_q, cursor_q;
  logic [7:0]        skip_q, pend_id_q;
  rtphx_pkg::phase_t phase_q;
  logic              two_q;

  assign pending_records = expected_records.size();

  task automatic clear_parse();
    pos_q = '0; flags_q = '0; mt_q = '0; seq_q = '0; ts_q = '0; ssrc_q = '0;
    prof_q = '0; ext_total_q = '0; cursor_q = '0; skip_q = '0;
    pend_id_q = '0; phase_q = rtphx_pkg::PH_FIXED; two_q = 1'b0;
  endtask

  function automatic rtphx_pkg::record_t blank(rtphx_pkg::rec_kind_t k);
    rtphx_pkg::record_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic logic [17:0] hdr_size();
    return two_q ? 18'd2 : 18'd1;
  endfunction

  task automatic walk_done_check();
    if (cursor_q + hdr_size() >= ext_total_q) phase_q = rtphx_pkg::PH_TAIL;
  endtask

  task automatic add_element(input logic [7:0] id, input logic [7:0] len,
                             inout rtphx_pkg::record_t recs[$]);
    rtphx_pkg::record_t r;
    logic [17:0] base;
    base = 18'd16 + 18'(flags_q[3:0]) * 18'd4;
    r = blank(two_q ? rtphx_pkg::REC_TWO_BYTE : rtphx_pkg::REC_ONE_BYTE);
    r.element_id = id;
    r.element_offset = 16'(base + cursor_q + hdr_size());
    r.element_length = len;
    recs.insert(recs.size(), r);
    cursor_q = cursor_q + hdr_size() + 18'(len);
    skip_q = len;
    if (cursor_q + hdr_size() >= ext_total_q) phase_q = rtphx_pkg::PH_TAIL;
    else phase_q = (len != 0) ? rtphx_pkg::PH_DATA : rtphx_pkg::PH_HDR;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eop);
    rtphx_pkg::record_t recs[$];
    rtphx_pkg::record_t r;
    logic [15:0] p;
    logic [17:0] start, rel;
    logic [7:0] len;
    p = pos_q;
    if (32'(p) < rtphx_pkg::MaxPacketBytes) begin
      unique case (phase_q)
        rtphx_pkg::PH_FIXED: begin
          if (p == 0) flags_q = b;
          else if (p == 1) mt_q = b;
          else if (p < 4) seq_q = {seq_q[7:0], b};
          else if (p < 8) ts_q = {ts_q[23:0], b};
          else if (p < 12) ssrc_q = {ssrc_q[23:0], b};
          if (p == 11) begin
            r = blank(rtphx_pkg::REC_HEADER);
            r.marker_bit = mt_q[7];
            r.payload_kind = mt_q[6:0];
            r.sequence_value = seq_q;
            r.time_stamp = ts_q;
            r.source_id = ssrc_q;
            r.contributor_count = flags_q[3:0];
            recs.insert(recs.size(), r);
            phase_q = flags_q[4] ? rtphx_pkg::PH_PRE : rtphx_pkg::PH_TAIL;
          end
        end
        rtphx_pkg::PH_PRE: begin
          start = 18'd12 + 18'(flags_q[3:0]) * 18'd4;
          if (18'(p) >= start) begin
            rel = 18'(p) - start;
            if (rel == 0) prof_q = {b, 8'h00};
            else if (rel == 1) begin
              prof_q[7:0] = b;
              if (prof_q == rtphx_pkg::ProfileOneByte) two_q = 1'b0;
              else if (prof_q == rtphx_pkg::ProfileTwoByte) two_q = 1'b1;
              else begin
                recs.insert(recs.size(), blank(rtphx_pkg::REC_BAD_PROF));
                phase_q = rtphx_pkg::PH_TAIL;
              end
            end else if (rel == 2) ext_total_q = 18'(b);
            else begin
              ext_total_q = {ext_total_q[7:0], b, 2'b00};
              cursor_q = '0;
              phase_q = rtphx_pkg::PH_HDR;
              walk_done_check();
            end
          end
        end
        rtphx_pkg::PH_HDR: begin
          if (b == 0) begin
            cursor_q++;
            walk_done_check();
          end else if (!two_q) begin
            len = 8'd1 + 8'(b[3:0]);
            if (b[7:4] == 4'hf || b[7:4] == 4'h0 ||
                cursor_q + 18'd1 + 18'(len) > ext_total_q) begin
              recs.insert(recs.size(), blank(rtphx_pkg::REC_STOPPED));
              phase_q = rtphx_pkg::PH_TAIL;
            end else add_element(8'(b[7:4]), len, recs);
          end else begin
            pend_id_q = b;
            phase_q = rtphx_pkg::PH_LEN;
          end
        end
        rtphx_pkg::PH_LEN: begin
          if (cursor_q + 18'd2 + 18'(b) > ext_total_q) begin
            recs.insert(recs.size(), blank(rtphx_pkg::REC_STOPPED));
            phase_q = rtphx_pkg::PH_TAIL;
          end else add_element(pend_id_q, b, recs);
        end
        rtphx_pkg::PH_DATA: begin
          if (skip_q > 0) skip_q--;
          if (skip_q == 0) phase_q = rtphx_pkg::PH_HDR;
        end
        default: ;
      endcase
      pos_q = p + 16'd1;
    end
    if (eop) begin
      r = blank(phase_q == rtphx_pkg::PH_TAIL ? rtphx_pkg::REC_END : rtphx_pkg::REC_TRUNC);
      if (phase_q == rtphx_pkg::PH_TAIL && flags_q[5]) r.padding_bytes = b;
      recs.insert(recs.size(), r);
      clear_parse();
    end
    if (recs.size() > 0) recs[recs.size() - 1].run_last = 1'b1;
    expected_records = {expected_records, recs};
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rtphx_pkg::record_t w;
    if (!rst_n) begin
      clear_parse();
      expected_records.delete();
      error_count = 0;
    end else begin
      if (in_valid && in_ready) predict_byte(in_packet_byte, in_end_of_packet);
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          error_count++;
          $display("%0t: unexpected record expected none actual kind %0d",
                   $time, out_record_kind);
        end else begin
          w = expected_records.pop_front();
          compare_field("kind", 32'(w.kind), 32'(out_record_kind));
          compare_field("marker", 32'(w.marker_bit), 32'(out_marker_bit));
          compare_field("ptype", 32'(w.payload_kind), 32'(out_payload_kind));
          compare_field("seq", 32'(w.sequence_value), 32'(out_sequence_value));
          compare_field("ts", w.time_stamp, out_time_stamp);
          compare_field("ssrc", w.source_id, out_source_id);
          compare_field("cc", 32'(w.contributor_count), 32'(out_contributor_count));
          compare_field("id", 32'(w.element_id), 32'(out_element_id));
          compare_field("offset", 32'(w.element_offset), 32'(out_element_offset));
          compare_field("length", 32'(w.element_length), 32'(out_element_length));
          compare_field("padding", 32'(w.padding_bytes), 32'(out_padding_bytes));
          compare_field("run_last", 32'(w.run_last), 32'(out_run_last));
        end
      end
    end
  end

endmodule

@@ sim/rtp_header_extension_parser_tb.sv @@
// Stimulus and verdict for the RTP header extension parser.
`timescale 1ns / 100ps
module rtp_header_extension_parser_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_packet_byte = '0;
  logic in_end_of_packet = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_record_kind;
  logic out_marker_bit;
  logic [6:0] out_payload_kind;
  logic [15:0] out_sequence_value;
  logic [31:0] out_time_stamp, out_source_id;
  logic [3:0] out_contributor_count;
  logic [7:0] out_element_id, out_element_length, out_padding_bytes;
  logic [15:0] out_element_offset;
  logic out_run_last;
  int error_count, pending_records;
  int cycle_count = 0;
  int bytes_sent = 0;
  int rx_wait = 0;
  logic long_hold = 1'b0;
  bit paused = 1'b0;

  always #5 clk = ~clk;

  rtp_header_extension_parser dut (.*);
  rtp_header_extension_parser_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one long receiver hold-off while the sender keeps offering bytes
  initial begin
    wait (bytes_sent > 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b0;
  end

  // receiver: draws a random wait for every item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = $urandom_range(0, 8);
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_wait = $urandom_range(0, 8);
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else out_ready <= 1'b1;
  end

  byte unsigned pkt[$];

  task automatic append_byte(input int unsigned v);
    pkt = {pkt, 8'(v)};
  endtask

  task automatic send_packet();
    int gap;
    foreach (pkt[i]) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_packet_byte <= pkt[i];
      in_end_of_packet <= (i == pkt.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // fixed header, optional extension: mode 0 one-byte, 1 two-byte, 2 bad
  task automatic build(input int cc, input bit x, input bit p, input int mode,
                       input int words, input bit junk);
    int total, k, len;
    pkt.delete();
    append_byte(($urandom_range(0, 3) << 6) | (32'(p) << 5) | (32'(x) << 4) | 32'(cc));
    repeat (11) append_byte($urandom_range(0, 255));
    repeat (cc * 4) append_byte($urandom_range(0, 255));
    if (x) begin
      if (mode == 0) begin append_byte(8'hBE); append_byte(8'hDE); end
      else if (mode == 1) begin append_byte(8'h10); append_byte(8'h00); end
      else begin append_byte($urandom_range(0, 255)); append_byte($urandom_range(0, 255)); end
      append_byte(words >> 8); append_byte(words);
      total = words * 4; k = 0;
      while (k < total) begin
        if (junk || $urandom_range(0, 5) == 0) begin
          append_byte($urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 255));
          k++;
        end else if (mode == 0) begin
          len = $urandom_range(0, 15);
          append_byte(($urandom_range(1, 14) << 4) | len);
          repeat (len + 1) append_byte($urandom_range(0, 255));
          k += len + 2;
        end else begin
          len = $urandom_range(0, 12);
          append_byte($urandom_range(0, 255));
          append_byte(len);
          repeat (len) append_byte($urandom_range(0, 255));
          k += len + 2;
        end
      end
    end
    repeat ($urandom_range(0, 4)) append_byte($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: all-ones header, one-byte, two-byte, stop ids, bad profile
    pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFF};
    send_packet();
    pkt = '{8'h30, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hBE, 8'hDE, 0, 1,
            8'h00, 8'h10, 8'hAA, 8'hF0, 8'h07};
    send_packet();
    pkt = '{8'h10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h10, 8'h00, 0, 1,
            8'hFF, 8'h02, 1, 2};
    send_packet();
    pkt = '{8'h10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hBE, 8'hDE, 0, 1,
            8'h05, 0, 0, 0};
    send_packet();
    pkt = '{8'h10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h12, 8'h34, 0};
    send_packet();
    while (bytes_sent < 1100) begin
      build($urandom_range(0, 3) == 0 ? 15 : $urandom_range(0, 2), $urandom_range(0, 7) != 0,
            $urandom_range(0, 1) == 1, $urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1),
            $urandom_range(0, 4), $urandom_range(0, 9) == 0);
      send_packet();
      if (bytes_sent > 800 && !paused) begin
        paused = 1'b1;
        @(posedge clk);
        wait (pending_records == 0);
      end
    end
    @(posedge clk);
    wait (pending_records == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
